### sv/sliding_window_latency_percentile_core_macros.svh
// Assertion macros for the sliding window latency percentile core.
// Included by the RTL files that carry concurrent assertions.
`ifndef SLIDING_WINDOW_LATENCY_PERCENTILE_CORE_MACROS_SVH
`define SLIDING_WINDOW_LATENCY_PERCENTILE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SWLP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SWLP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/swlp_pkg.sv
// Shared widths, constants and controller/datapath interface types.
// No dependencies.
`default_nettype none
package swlp_pkg;
    localparam int WINDOW   = 1024;
    localparam int LAT_W    = 16;
    localparam int CNT_W    = 32;
    localparam int MEAN_W   = 24;
    localparam int FRAC_W   = 8;
    localparam int AW       = $clog2(WINDOW);
    localparam int FILL_W   = $clog2(WINDOW + 1);
    localparam int SUM_W    = LAT_W + $clog2(WINDOW);
    localparam int DIV_W    = SUM_W + FRAC_W;
    localparam int PCT_W    = 7;
    localparam int X_W      = FILL_W + PCT_W;
    localparam int RCP_W    = 20;
    localparam int RCP_SH   = 26;
    localparam int PROD_W   = X_W + RCP_W;

    localparam logic [PCT_W-1:0] PCT95     = PCT_W'(95);
    localparam logic [PCT_W-1:0] PCT99     = PCT_W'(99);
    localparam logic [PCT_W-1:0] PCT_ROUND = PCT_W'(99);
    // ceil(2^26 / 100): exact floor(x/100) for every x this block forms
    localparam logic [RCP_W-1:0] RCP100    = RCP_W'(671089);

    typedef struct packed {
        logic accept;
        logic rd;
        logic old;
        logic scan;
        logic idx;
        logic pa;
        logic pb;
        logic pc;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic div_done;
    } sts_t;
endpackage
`default_nettype wire

### sv/swlp_div.sv
// Restoring divider, one quotient bit per cycle.
// Uses swlp_pkg widths.
`default_nettype none
module swlp_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [swlp_pkg::DIV_W-1:0] dividend,
    input  wire logic [swlp_pkg::FILL_W-1:0] divisor,
    output logic                            busy,
    output logic [swlp_pkg::DIV_W-1:0]      quotient
);
    localparam int STEP_W = $clog2(swlp_pkg::DIV_W + 1);

    logic [swlp_pkg::DIV_W-1:0]  quo_reg;
    logic [swlp_pkg::FILL_W-1:0] rem_reg, den_reg;
    logic [STEP_W-1:0]           step_reg;
    logic                        busy_reg;
    logic [swlp_pkg::FILL_W:0]   trial;
    logic                        fits;

    assign trial = {rem_reg, quo_reg[swlp_pkg::DIV_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(swlp_pkg::DIV_W);
        end else if (busy_reg) begin
            step_reg <= step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1)) busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[swlp_pkg::DIV_W-2:0], fits};
            rem_reg <= fits ? swlp_pkg::FILL_W'(trial - {1'b0, den_reg})
                            : trial[swlp_pkg::FILL_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

### sv/swlp_dp.sv
// Datapath: counters, sample ring, ping-pong sorted window, percentile
// index math, mean divider and result registers. Uses swlp_pkg, swlp_div.
`default_nettype none
module swlp_dp (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire swlp_pkg::cmd_t              cmd,
    output swlp_pkg::sts_t                   sts,
    input  wire logic                        s_success,
    input  wire logic [swlp_pkg::LAT_W-1:0]  s_latency,
    output logic [swlp_pkg::CNT_W-1:0]       m_total_count,
    output logic [swlp_pkg::CNT_W-1:0]       m_success_count,
    output logic [swlp_pkg::CNT_W-1:0]       m_failed_count,
    output logic [swlp_pkg::MEAN_W-1:0]      m_mean_latency_q8,
    output logic [swlp_pkg::LAT_W-1:0]       m_p95_latency,
    output logic [swlp_pkg::LAT_W-1:0]       m_p99_latency
);
    localparam int AW = swlp_pkg::AW;
    localparam int FW = swlp_pkg::FILL_W;
    localparam int LW = swlp_pkg::LAT_W;
    localparam int CW = swlp_pkg::CNT_W;
    localparam int SW = swlp_pkg::SUM_W;
    localparam logic [CW-1:0] CNT_MAX = '1;

    logic [LW-1:0] ring_mem [swlp_pkg::WINDOW];
    logic [LW-1:0] srt_a    [swlp_pkg::WINDOW];
    logic [LW-1:0] srt_b    [swlp_pkg::WINDOW];
    logic [LW-1:0] ring_q, srt_q;

    logic [LW-1:0] lat_reg;
    logic [CW-1:0] tot_reg, suc_reg, fail_reg;
    logic [AW-1:0] wp_reg;
    logic [FW-1:0] fill_reg, c_reg, w_reg;
    logic [SW-1:0] sum_reg;
    logic          sel_reg, ins_reg, rem_reg;
    logic [swlp_pkg::PROD_W-1:0] prod95_reg, prod99_reg;
    logic [LW-1:0] p95_reg, p99_reg;

    logic          full, avail;
    logic          srt_we, srt_re, consume;
    logic [LW-1:0] srt_wd;
    logic [AW-1:0] srt_ra;
    logic          ins_next, rem_next;
    logic [FW-1:0] q95, q99;
    logic [AW-1:0] idx95, idx99;
    logic [swlp_pkg::X_W-1:0] x95, x99;
    logic          div_busy;
    logic [swlp_pkg::DIV_W-1:0] div_q;

    assign full  = fill_reg == FW'(swlp_pkg::WINDOW);
    assign avail = c_reg != fill_reg;

    // merge pass: old sorted copy minus the evicted sample plus the new one
    always_comb begin
        srt_we   = 1'b0;
        srt_wd   = srt_q;
        consume  = 1'b0;
        ins_next = ins_reg;
        rem_next = rem_reg;
        if (cmd.scan) begin
            if (!avail) begin
                srt_we = !ins_reg;
                srt_wd = lat_reg;
            end else if (!ins_reg && srt_q > lat_reg) begin
                srt_we   = 1'b1;
                srt_wd   = lat_reg;
                ins_next = 1'b1;
            end else if (full && !rem_reg && srt_q == ring_q) begin
                rem_next = 1'b1;
                consume  = 1'b1;
            end else begin
                srt_we  = 1'b1;
                consume = 1'b1;
            end
        end
    end

    assign q95   = prod95_reg[swlp_pkg::RCP_SH +: FW];
    assign q99   = prod99_reg[swlp_pkg::RCP_SH +: FW];
    assign idx95 = (q95 == '0) ? '0 : AW'(q95 - FW'(1));
    assign idx99 = (q99 == '0) ? '0 : AW'(q99 - FW'(1));
    assign x95   = swlp_pkg::X_W'(fill_reg) * swlp_pkg::X_W'(swlp_pkg::PCT95)
                 + swlp_pkg::X_W'(swlp_pkg::PCT_ROUND);
    assign x99   = swlp_pkg::X_W'(fill_reg) * swlp_pkg::X_W'(swlp_pkg::PCT99)
                 + swlp_pkg::X_W'(swlp_pkg::PCT_ROUND);

    always_comb begin
        srt_re = 1'b0;
        srt_ra = '0;
        if (cmd.rd) begin
            srt_re = 1'b1;
        end else if (consume) begin
            srt_re = 1'b1;
            srt_ra = AW'(c_reg + FW'(1));
        end else if (cmd.pa) begin
            srt_re = 1'b1;
            srt_ra = idx95;
        end else if (cmd.pb) begin
            srt_re = 1'b1;
            srt_ra = idx99;
        end
    end

    // sorted copies: read bank sel, write the other
    always_ff @(posedge aclk) begin
        if (srt_we) begin
            if (sel_reg) srt_a[w_reg[AW-1:0]] <= srt_wd;
            else         srt_b[w_reg[AW-1:0]] <= srt_wd;
        end
        if (srt_re) srt_q <= sel_reg ? srt_b[srt_ra] : srt_a[srt_ra];
    end

    always_ff @(posedge aclk) begin
        if (cmd.old) ring_mem[wp_reg] <= lat_reg;
        if (cmd.rd)  ring_q <= ring_mem[wp_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tot_reg  <= '0;
            suc_reg  <= '0;
            fail_reg <= '0;
            wp_reg   <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
            sel_reg  <= 1'b0;
            c_reg    <= '0;
            w_reg    <= '0;
            ins_reg  <= 1'b0;
            rem_reg  <= 1'b0;
        end else begin
            if (cmd.accept) begin
                if (tot_reg != CNT_MAX) tot_reg <= tot_reg + CW'(1);
                if (s_success && suc_reg != CNT_MAX) suc_reg <= suc_reg + CW'(1);
                if (!s_success && fail_reg != CNT_MAX) fail_reg <= fail_reg + CW'(1);
            end
            if (cmd.rd) begin
                c_reg   <= '0;
                w_reg   <= '0;
                ins_reg <= 1'b0;
                rem_reg <= 1'b0;
            end
            if (cmd.old) begin
                sum_reg <= sum_reg - (full ? SW'(ring_q) : SW'(0)) + SW'(lat_reg);
            end
            if (cmd.scan) begin
                ins_reg <= ins_next;
                rem_reg <= rem_next;
                if (consume) c_reg <= c_reg + FW'(1);
                if (srt_we)  w_reg <= w_reg + FW'(1);
                if (!avail) begin
                    sel_reg <= !sel_reg;
                    if (!full) fill_reg <= fill_reg + FW'(1);
                    wp_reg <= (32'(wp_reg) + 1 >= swlp_pkg::WINDOW) ? '0
                                                                 : wp_reg + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            lat_reg <= s_latency;
        end
        if (cmd.idx) begin
            prod95_reg <= swlp_pkg::PROD_W'(x95) * swlp_pkg::PROD_W'(swlp_pkg::RCP100);
            prod99_reg <= swlp_pkg::PROD_W'(x99) * swlp_pkg::PROD_W'(swlp_pkg::RCP100);
        end
        if (cmd.pb) p95_reg <= srt_q;
        if (cmd.pc) p99_reg <= srt_q;
        if (cmd.load) begin
            m_total_count     <= tot_reg;
            m_success_count   <= suc_reg;
            m_failed_count    <= fail_reg;
            m_mean_latency_q8 <= div_q[swlp_pkg::MEAN_W-1:0];
            m_p95_latency     <= p95_reg;
            m_p99_latency     <= p99_reg;
        end
    end

    swlp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.idx),
        .dividend ({sum_reg, {swlp_pkg::FRAC_W{1'b0}}}),
        .divisor  (fill_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign sts = '{scan_last: cmd.scan && !avail, div_done: !div_busy};
endmodule
`default_nettype wire

### sv/swlp_ctrl.sv
// Controller state machine sequencing one item through the datapath.
// Uses swlp_pkg types and the assertion macro header.
`default_nettype none
`include "sliding_window_latency_percentile_core_macros.svh"
module swlp_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  wire logic           m_ready,
    output swlp_pkg::cmd_t      cmd,
    input  wire swlp_pkg::sts_t sts
);
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RD   = 4'd1;
    localparam logic [3:0] ST_OLD  = 4'd2;
    localparam logic [3:0] ST_SCAN = 4'd3;
    localparam logic [3:0] ST_IDX  = 4'd4;
    localparam logic [3:0] ST_PA   = 4'd5;
    localparam logic [3:0] ST_PB   = 4'd6;
    localparam logic [3:0] ST_PC   = 4'd7;
    localparam logic [3:0] ST_WAIT = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                cmd.rd     = 1'b1;
                state_next = ST_OLD;
            end
            ST_OLD: begin
                cmd.old    = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_last) state_next = ST_IDX;
            end
            ST_IDX: begin
                cmd.idx    = 1'b1;
                state_next = ST_PA;
            end
            ST_PA: begin
                cmd.pa     = 1'b1;
                state_next = ST_PB;
            end
            ST_PB: begin
                cmd.pb     = 1'b1;
                state_next = ST_PC;
            end
            ST_PC: begin
                cmd.pc     = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (sts.div_done && out_free) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load)          m_valid_next = 1'b1;
        else if (m_ready)      m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;

    `SWLP_ASSERT_IMP(a_load_free, aclk, aresetn, cmd.load, !m_valid_reg || m_ready, "result overwritten")
    `SWLP_ASSERT_NXT(a_accept_rd, aclk, aresetn, s_valid && s_ready, state_reg == ST_RD, "accept did not start read")
    `SWLP_ASSERT_NXT(a_scan_idx, aclk, aresetn, cmd.scan && sts.scan_last, state_reg == ST_IDX, "scan end lost")
endmodule
`default_nettype wire

### sv/sliding_window_latency_percentile_core.sv
// Sliding window latency percentile core: top level.
// Uses swlp_pkg, swlp_ctrl and swlp_dp.
//
// Takes one request record (success flag, latency in ms) per item and returns
// one result item: saturating total/success/failure counts, the mean of the
// last 1024 latencies in Q8 (truncated), and the 95th and 99th percentile of
// that window. The sorted copy of the window is rebuilt for each item by a
// merge pass that reads one entry per cycle, pausing while the new sample is
// inserted, from one bank of a ping-pong RAM pair and writes the other, and
// the 34-bit mean divider retires one quotient bit per cycle. A finished
// result sits in the output register while the next item is accepted; the
// core stalls at its final step until the mean divider is done and that
// result has been taken. Ring and sorted RAMs need no clearing after reset
// since the fill count bounds reads.
`default_nettype none
module sliding_window_latency_percentile_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_success,
    input  wire logic [swlp_pkg::LAT_W-1:0]  s_latency,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [swlp_pkg::CNT_W-1:0]       m_total_count,
    output logic [swlp_pkg::CNT_W-1:0]       m_success_count,
    output logic [swlp_pkg::CNT_W-1:0]       m_failed_count,
    output logic [swlp_pkg::MEAN_W-1:0]      m_mean_latency_q8,
    output logic [swlp_pkg::LAT_W-1:0]       m_p95_latency,
    output logic [swlp_pkg::LAT_W-1:0]       m_p99_latency
);
    // command and status between sequencer and datapath
    swlp_pkg::cmd_t cmd;
    swlp_pkg::sts_t sts;

    swlp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // datapath holds the counters, sample RAMs and the result register
    swlp_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .s_success         (s_success),
        .s_latency         (s_latency),
        .m_total_count     (m_total_count),
        .m_success_count   (m_success_count),
        .m_failed_count    (m_failed_count),
        .m_mean_latency_q8 (m_mean_latency_q8),
        .m_p95_latency     (m_p95_latency),
        .m_p99_latency     (m_p99_latency)
    );
endmodule
`default_nettype wire
